// ===== hdl/tmnn_pkg.sv =====
// ----------------------------------------------------------------------------
// tmnn_pkg
// Shared types and constants of the topological map nearest-node engine.
// ----------------------------------------------------------------------------
`default_nettype none

package tmnn_pkg;

  localparam int COORD_W = 28;
  localparam int LIM_W   = 27;
  localparam int SQ_W    = 2 * COORD_W;
  localparam int DIST_W  = SQ_W + 2;
  localparam int LSQ_W   = 2 * LIM_W;
  localparam int KIND_W  = 3;
  localparam int STAT_W  = 2;
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 32;

  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR   = 3'd0,
    KIND_APPEND  = 3'd1,
    KIND_EDGE    = 3'd2,
    KIND_NEAREST = 3'd3,
    KIND_NEARBY  = 3'd4
  } kind_t;

  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BAD_NODE = 2'd2;
  localparam logic [STAT_W-1:0] STAT_DEG_FULL = 2'd3;

  localparam logic REG_NEAREST_LIMIT = 1'b0;
  localparam logic REG_NEARBY_RADIUS = 1'b1;

  localparam logic [LIM_W-1:0] NEAREST_LIMIT_RST = 27'd25600000;
  localparam logic [LIM_W-1:0] NEARBY_RADIUS_RST = 27'd256;

  typedef struct packed {
    logic vld;
    logic first;
  } tag_t;

endpackage

`default_nettype wire

// ===== hdl/tmnn_dist.sv =====
// ----------------------------------------------------------------------------
// tmnn_dist
// Three-stage squared distance pipeline: absolute differences, squares, sum.
// ----------------------------------------------------------------------------
`default_nettype none

module tmnn_dist
  import tmnn_pkg::*;
#(
  parameter int ID_W = 10
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire tag_t                      in_tag,
  input  wire logic [ID_W-1:0]           in_id,
  input  wire logic signed [COORD_W-1:0] node_x,
  input  wire logic signed [COORD_W-1:0] node_y,
  input  wire logic signed [COORD_W-1:0] node_z,
  input  wire logic signed [COORD_W-1:0] q_x,
  input  wire logic signed [COORD_W-1:0] q_y,
  input  wire logic signed [COORD_W-1:0] q_z,
  output tag_t                           out_tag,
  output logic [ID_W-1:0]                out_id,
  output logic [DIST_W-1:0]              out_dist,
  output logic                           active
);

  tag_t              s1_tag_r, s2_tag_r, s3_tag_r;
  logic [ID_W-1:0]   s1_id_r, s2_id_r, s3_id_r;
  logic [COORD_W-1:0] ax_r, ay_r, az_r;
  logic [SQ_W-1:0]   sx_r, sy_r, sz_r;
  logic [DIST_W-1:0] sum_r;

  function automatic logic [COORD_W-1:0] abs_diff(input logic signed [COORD_W-1:0] a,
                                                  input logic signed [COORD_W-1:0] b);
    logic signed [COORD_W:0] d;
    logic signed [COORD_W:0] m;
    d = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
    m = d[COORD_W] ? -d : d;
    return m[COORD_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_tag_r <= '0;
      s2_tag_r <= '0;
      s3_tag_r <= '0;
    end else begin
      s1_tag_r <= in_tag;
      s2_tag_r <= s1_tag_r;
      s3_tag_r <= s2_tag_r;
    end
    s1_id_r <= in_id;
    s2_id_r <= s1_id_r;
    s3_id_r <= s2_id_r;
    ax_r    <= abs_diff(node_x, q_x);
    ay_r    <= abs_diff(node_y, q_y);
    az_r    <= abs_diff(node_z, q_z);
    sx_r    <= SQ_W'(ax_r) * SQ_W'(ax_r);
    sy_r    <= SQ_W'(ay_r) * SQ_W'(ay_r);
    sz_r    <= SQ_W'(az_r) * SQ_W'(az_r);
    sum_r   <= DIST_W'(sx_r) + DIST_W'(sy_r) + DIST_W'(sz_r);
  end

  assign out_tag  = s3_tag_r;
  assign out_id   = s3_id_r;
  assign out_dist = sum_r;
  assign active   = s1_tag_r.vld | s2_tag_r.vld | s3_tag_r.vld;

endmodule

`default_nettype wire

// ===== hdl/topological_map_nearest_node_top.sv =====
// ----------------------------------------------------------------------------
// topological_map_nearest_node_top
// Map node table with bounded neighbor lists, nearest and nearby queries.
// ----------------------------------------------------------------------------
// Clear and append are done directly from the idle state; an edge reads both nodes,
// checks the degrees and writes both back, but stops after the check if a node is full.
// Nearest reads node memory once per node; nearby walks the neighbor list.
// One item is worked on at a time; busy is high while an item is in progress.
// Reset empties the table at once (no clearing pass) and loads register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module topological_map_nearest_node_top
  import tmnn_pkg::*;
#(
  parameter int MAX_NODES  = 1024,
  parameter int MAX_DEGREE = 8
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic [KIND_W-1:0]                    in_kind,
  input  wire logic signed [COORD_W-1:0]            in_pos_x,
  input  wire logic signed [COORD_W-1:0]            in_pos_y,
  input  wire logic signed [COORD_W-1:0]            in_pos_z,
  input  wire logic [$clog2(MAX_NODES)-1:0]         in_node_a,
  input  wire logic [$clog2(MAX_NODES)-1:0]         in_node_b,
  output logic                                      out_valid,
  output logic                                      out_found,
  output logic [$clog2(MAX_NODES)-1:0]              out_node_id,
  output logic [STAT_W-1:0]                         out_status,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [CFG_AW-1:0]                    paddr,
  input  wire logic [CFG_DW-1:0]                    pwdata,
  output logic [CFG_DW-1:0]                         prdata,
  output logic                                      pready
);

  localparam int ID_W    = $clog2(MAX_NODES);
  localparam int CNT_W   = $clog2(MAX_NODES + 1);
  localparam int DEG_W   = $clog2(MAX_DEGREE + 1);
  localparam int NB_AW   = $clog2(MAX_NODES * MAX_DEGREE);
  localparam int NB_D    = MAX_NODES * MAX_DEGREE;
  localparam int POS_W   = 3 * COORD_W;
  localparam int NODE_W  = POS_W + DEG_W;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_NB_HEAD,
    ST_NB_DEG,
    ST_NB_LIST,
    ST_DRAIN,
    ST_ED_RA,
    ST_ED_RB,
    ST_ED_CHK,
    ST_ED_WB
  } state_t;

  state_t             state_r;
  logic [LIM_W-1:0]   limit_r, radius_r;
  logic [CNT_W-1:0]   total_r;
  logic [ID_W-1:0]    a_r, b_r, i_r, bid_r;
  logic [DEG_W-1:0]   k_r, deg_r, deg_b_eff_r;
  logic signed [COORD_W-1:0] qx_r, qy_r, qz_r;
  logic [NODE_W-1:0]  word_a_r;
  logic [POS_W-1:0]   pos_b_r;
  logic [DIST_W-1:0]  best_r;
  logic [LSQ_W-1:0]   lsq_r;
  logic               mode_near_r, found_r, nb_vld_r;
  tag_t               rd_tag_r;
  logic [ID_W-1:0]    rd_id_r;

  logic               out_valid_r, out_found_r;
  logic [ID_W-1:0]    out_node_id_r;
  logic [STAT_W-1:0]  out_status_r;

  logic [NODE_W-1:0]  node_mem_r [MAX_NODES];
  logic [NODE_W-1:0]  node_rdata_r;
  logic [ID_W-1:0]    nb_mem_r [NB_D];
  logic [ID_W-1:0]    nb_rdata_r;

  logic               accept, cfg_wr;
  logic [ID_W-1:0]    node_raddr, node_waddr;
  logic               node_we;
  logic [NODE_W-1:0]  node_wdata;
  logic [NB_AW-1:0]   nb_raddr, nb_waddr;
  logic               nb_we;
  logic [ID_W-1:0]    nb_wdata;
  logic               pipe_issue, pipe_first;
  logic [DEG_W-1:0]   deg_a, deg_b;
  logic               edge_full;
  logic [LIM_W-1:0]   sq_src;
  logic [LSQ_W-1:0]   sq_val;
  tag_t               dist_tag;
  logic [ID_W-1:0]    dist_id;
  logic [DIST_W-1:0]  dist_val;
  logic               dist_active, take, drain_done;

  assign accept = start & ~busy;
  assign busy   = (state_r != ST_IDLE);
  assign cfg_wr = psel & penable & pwrite & pready;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_NEARBY_RADIUS) ? CFG_DW'(radius_r) : CFG_DW'(limit_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r  <= NEAREST_LIMIT_RST;
      radius_r <= NEARBY_RADIUS_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_NEAREST_LIMIT) begin
        limit_r <= pwdata[LIM_W-1:0];
      end else begin
        radius_r <= pwdata[LIM_W-1:0];
      end
    end
  end

  assign deg_a = word_a_r[DEG_W-1:0];
  assign deg_b = node_rdata_r[DEG_W-1:0];

  always_comb begin
    if (a_r == b_r) begin
      edge_full = ({1'b0, deg_a} + (DEG_W+1)'(2)) > (DEG_W+1)'(MAX_DEGREE);
    end else begin
      edge_full = (deg_a >= DEG_W'(MAX_DEGREE)) || (deg_b >= DEG_W'(MAX_DEGREE));
    end
  end

  assign sq_src = (in_kind == KIND_NEAREST) ? limit_r : radius_r;
  assign sq_val = LSQ_W'(sq_src) * LSQ_W'(sq_src);

  always_comb begin
    node_raddr = a_r;
    pipe_issue = 1'b0;
    pipe_first = 1'b0;
    if (nb_vld_r) begin
      node_raddr = nb_rdata_r;
      pipe_issue = 1'b1;
    end else begin
      case (state_r)
        ST_SCAN: begin
          node_raddr = i_r;
          pipe_issue = 1'b1;
        end
        ST_NB_HEAD: begin
          pipe_issue = 1'b1;
          pipe_first = 1'b1;
        end
        ST_ED_RB: begin
          node_raddr = b_r;
        end
        default: begin
        end
      endcase
    end
  end

  assign nb_raddr = NB_AW'(a_r) * NB_AW'(MAX_DEGREE) + NB_AW'(k_r);

  always_comb begin
    node_we    = 1'b0;
    node_waddr = a_r;
    node_wdata = word_a_r;
    nb_we      = 1'b0;
    nb_waddr   = NB_AW'(a_r) * NB_AW'(MAX_DEGREE) + NB_AW'(deg_a);
    nb_wdata   = b_r;
    case (state_r)
      ST_IDLE: begin
        node_we    = accept && (in_kind == KIND_APPEND) && (total_r < CNT_W'(MAX_NODES));
        node_waddr = total_r[ID_W-1:0];
        node_wdata = {in_pos_x, in_pos_y, in_pos_z, DEG_W'(0)};
      end
      ST_ED_CHK: begin
        node_we    = ~edge_full;
        nb_we      = ~edge_full;
        node_wdata = {word_a_r[NODE_W-1:DEG_W], deg_a + DEG_W'(1)};
      end
      ST_ED_WB: begin
        node_we    = 1'b1;
        nb_we      = 1'b1;
        node_waddr = b_r;
        node_wdata = {pos_b_r, deg_b_eff_r + DEG_W'(1)};
        nb_waddr   = NB_AW'(b_r) * NB_AW'(MAX_DEGREE) + NB_AW'(deg_b_eff_r);
        nb_wdata   = a_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem_r[node_waddr] <= node_wdata;
    end
    node_rdata_r <= node_mem_r[node_raddr];
  end

  always_ff @(posedge clk) begin
    if (nb_we) begin
      nb_mem_r[nb_waddr] <= nb_wdata;
    end
    nb_rdata_r <= nb_mem_r[nb_raddr];
  end

  tmnn_dist #(
    .ID_W(ID_W)
  ) u_dist (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_tag  (rd_tag_r),
    .in_id   (rd_id_r),
    .node_x  (node_rdata_r[NODE_W-1 -: COORD_W]),
    .node_y  (node_rdata_r[NODE_W-COORD_W-1 -: COORD_W]),
    .node_z  (node_rdata_r[NODE_W-2*COORD_W-1 -: COORD_W]),
    .q_x     (qx_r),
    .q_y     (qy_r),
    .q_z     (qz_r),
    .out_tag (dist_tag),
    .out_id  (dist_id),
    .out_dist(dist_val),
    .active  (dist_active)
  );

  assign take = dist_tag.vld &&
                (dist_tag.first ||
                 ((dist_val < best_r) && (mode_near_r || (dist_val < DIST_W'(lsq_r)))));
  assign drain_done = ~rd_tag_r.vld & ~nb_vld_r & ~dist_active;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      total_r     <= '0;
      out_valid_r <= 1'b0;
      nb_vld_r    <= 1'b0;
      rd_tag_r    <= '0;
    end else begin
      out_valid_r    <= 1'b0;
      nb_vld_r       <= (state_r == ST_NB_LIST);
      rd_tag_r.vld   <= pipe_issue;
      rd_tag_r.first <= pipe_first;
      rd_id_r        <= node_raddr;
      if (take) begin
        best_r  <= dist_val;
        bid_r   <= dist_id;
        found_r <= 1'b1;
      end
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            a_r           <= in_node_a;
            b_r           <= in_node_b;
            qx_r          <= in_pos_x;
            qy_r          <= in_pos_y;
            qz_r          <= in_pos_z;
            i_r           <= '0;
            k_r           <= '0;
            found_r       <= 1'b0;
            bid_r         <= '0;
            best_r        <= DIST_W'(sq_val);
            lsq_r         <= sq_val;
            mode_near_r   <= (in_kind == KIND_NEAREST);
            out_found_r   <= 1'b0;
            out_node_id_r <= '0;
            out_status_r  <= STAT_OK;
            case (in_kind)
              KIND_CLEAR: begin
                total_r     <= '0;
                out_valid_r <= 1'b1;
              end
              KIND_APPEND: begin
                out_valid_r <= 1'b1;
                if (total_r < CNT_W'(MAX_NODES)) begin
                  total_r       <= total_r + CNT_W'(1);
                  out_node_id_r <= total_r[ID_W-1:0];
                end else begin
                  out_status_r <= STAT_FULL;
                end
              end
              KIND_EDGE: begin
                if ((CNT_W'(in_node_a) < total_r) && (CNT_W'(in_node_b) < total_r)) begin
                  state_r <= ST_ED_RA;
                end else begin
                  out_valid_r  <= 1'b1;
                  out_status_r <= STAT_BAD_NODE;
                end
              end
              KIND_NEAREST: begin
                if (total_r == '0) begin
                  out_valid_r <= 1'b1;
                end else begin
                  state_r <= ST_SCAN;
                end
              end
              KIND_NEARBY: begin
                if (CNT_W'(in_node_a) < total_r) begin
                  state_r <= ST_NB_HEAD;
                end else begin
                  out_valid_r  <= 1'b1;
                  out_status_r <= STAT_BAD_NODE;
                end
              end
              default: begin
                out_valid_r <= 1'b1;
              end
            endcase
          end
        end
        ST_SCAN: begin
          i_r <= i_r + ID_W'(1);
          if (CNT_W'(i_r) + CNT_W'(1) == total_r) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_NB_HEAD: begin
          state_r <= ST_NB_DEG;
        end
        ST_NB_DEG: begin
          deg_r <= deg_b;
          if (deg_b == '0) begin
            state_r <= ST_DRAIN;
          end else begin
            state_r <= ST_NB_LIST;
          end
        end
        ST_NB_LIST: begin
          k_r <= k_r + DEG_W'(1);
          if (k_r + DEG_W'(1) == deg_r) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (drain_done) begin
            state_r       <= ST_IDLE;
            out_valid_r   <= 1'b1;
            out_found_r   <= found_r;
            out_node_id_r <= bid_r;
            out_status_r  <= STAT_OK;
          end
        end
        ST_ED_RA: begin
          state_r <= ST_ED_RB;
        end
        ST_ED_RB: begin
          word_a_r <= node_rdata_r;
          state_r  <= ST_ED_CHK;
        end
        ST_ED_CHK: begin
          pos_b_r <= node_rdata_r[NODE_W-1:DEG_W];
          if (a_r == b_r) begin
            deg_b_eff_r <= deg_a + DEG_W'(1);
          end else begin
            deg_b_eff_r <= deg_b;
          end
          if (edge_full) begin
            state_r      <= ST_IDLE;
            out_valid_r  <= 1'b1;
            out_status_r <= STAT_DEG_FULL;
          end else begin
            state_r <= ST_ED_WB;
          end
        end
        ST_ED_WB: begin
          state_r      <= ST_IDLE;
          out_valid_r  <= 1'b1;
          out_status_r <= STAT_OK;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid   = out_valid_r;
  assign out_found   = out_found_r;
  assign out_node_id = out_node_id_r;
  assign out_status  = out_status_r;

endmodule

`default_nettype wire
